@@ rtl/phce_pkg.sv @@
// Package for the pixel hit cluster encoder.
// Holds request codes, field widths, range limits and the stage types.
// No dependencies.
package phce_pkg;

	localparam int unsigned REQ_W    = 2;
	localparam int unsigned ENC_W    = 4;
	localparam int unsigned ADDR_W   = 10;
	localparam int unsigned WMAP_W   = 7;

	localparam int unsigned ENCODERS_PER_REGION = 16;
	localparam int unsigned PIXELS_PER_ENCODER  = 1024;

	typedef logic [REQ_W-1:0]  req_code_t;
	typedef logic [ENC_W-1:0]  enc_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [WMAP_W-1:0] wmap_t;

	localparam req_code_t REQ_HIT   = 2'd0;
	localparam req_code_t REQ_END   = 2'd1;
	localparam req_code_t REQ_ABORT = 2'd2;

	typedef struct packed {
		req_code_t req_type;
		enc_t      hit_encoder;
		addr_t     hit_address;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

endpackage

@@ rtl/phce_req_if.sv @@
// Request channel of the pixel hit cluster encoder: hit, end of region or abort.
// Depends on phce_pkg.
interface phce_req_if;
	logic               valid;
	logic               ready;
	phce_pkg::req_code_t req_type;
	phce_pkg::enc_t      hit_encoder;
	phce_pkg::addr_t     hit_address;

	modport source (output valid, req_type, hit_encoder, hit_address, input ready);
	modport sink   (input valid, req_type, hit_encoder, hit_address, output ready);
endinterface

@@ rtl/phce_word_if.sv @@
// Data word channel of the pixel hit cluster encoder: short and long words.
// Depends on phce_pkg.
interface phce_word_if;
	logic            valid;
	logic            ready;
	logic            word_long;
	phce_pkg::enc_t  word_encoder;
	phce_pkg::addr_t word_base;
	phce_pkg::wmap_t word_map;

	modport source (output valid, word_long, word_encoder, word_base, word_map, input ready);
	modport sink   (input valid, word_long, word_encoder, word_base, word_map, output ready);
endinterface

@@ rtl/phce_cfg_if.sv @@
// Configuration write channel of the pixel hit cluster encoder.
// Carries the clustering register value. No dependencies.
interface phce_cfg_if;
	logic valid;
	logic ready;
	logic clustering;

	modport source (output valid, clustering, input ready);
	modport sink   (input valid, clustering, output ready);
endinterface

@@ rtl/phce_in_reg.sv @@
// Input register stage of the pixel hit cluster encoder.
// Depends on phce_pkg and phce_req_if.
module phce_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	phce_req_if.sink         req,
	input  logic             advance,
	output phce_pkg::stage_t s1
);
	import phce_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{req_type: req.req_type, hit_encoder: req.hit_encoder,
				hit_address: req.hit_address};
		end
	end

	assign s1 = '{valid: valid_s1, item: item_s1};

endmodule

@@ rtl/phce_cluster.sv @@
// Cluster state, join decision and result register of the pixel hit cluster encoder.
// Depends on phce_pkg and phce_word_if.
module phce_cluster #(
	parameter int unsigned MAP_BITS = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  phce_pkg::stage_t s1,
	input  logic             clustering,
	output logic             advance,
	phce_word_if.source      word
);
	import phce_pkg::*;

	localparam int unsigned DIFF_W = ADDR_W + 1;
	localparam int unsigned POS_W  = $clog2(MAP_BITS + 1);

	typedef logic [MAP_BITS-1:0] map_t;

	logic  cluster_open_q;
	enc_t  open_encoder_q;
	addr_t open_base_q;
	map_t  open_map_q;

	logic  word_valid_q;
	logic  word_long_q;
	enc_t  word_encoder_q;
	addr_t word_base_q;
	wmap_t word_map_q;

	logic               hit_ok;
	logic [DIFF_W-1:0]  diff;
	logic               joins;
	logic [POS_W-1:0]   pos;
	map_t               map_set;
	logic               open_n;
	enc_t               encoder_n;
	addr_t              base_n;
	map_t               map_n;
	logic               emit;
	logic               emit_long;
	enc_t               emit_encoder;
	addr_t              emit_base;
	map_t               emit_map;
	logic [WMAP_W+MAP_BITS-1:0] emit_map_ext;

	assign advance = !word_valid_q || word.ready;

	assign hit_ok = (32'(s1.item.hit_encoder) < ENCODERS_PER_REGION) &&
		(32'(s1.item.hit_address) < PIXELS_PER_ENCODER);
	assign diff = {1'b0, s1.item.hit_address} - {1'b0, open_base_q};
	assign joins = (s1.item.hit_encoder == open_encoder_q) &&
		(s1.item.hit_address > open_base_q) && (diff <= DIFF_W'(MAP_BITS));
	assign pos = POS_W'(diff - DIFF_W'(1));
	assign map_set = open_map_q | (map_t'(1) << pos);

	always_comb begin
		open_n       = cluster_open_q;
		encoder_n    = open_encoder_q;
		base_n       = open_base_q;
		map_n        = open_map_q;
		emit         = 1'b0;
		emit_long    = (open_map_q != '0);
		emit_encoder = open_encoder_q;
		emit_base    = open_base_q;
		emit_map     = open_map_q;
		unique case (s1.item.req_type)
			REQ_ABORT: begin
				open_n = 1'b0;
				map_n  = '0;
			end
			REQ_END: begin
				if (cluster_open_q) begin
					emit   = 1'b1;
					open_n = 1'b0;
					map_n  = '0;
				end
			end
			REQ_HIT: begin
				if (hit_ok) begin
					if (!clustering) begin
						emit         = 1'b1;
						emit_long    = 1'b0;
						emit_encoder = s1.item.hit_encoder;
						emit_base    = s1.item.hit_address;
						emit_map     = '0;
					end else if (cluster_open_q && joins) begin
						if (pos == POS_W'(MAP_BITS - 1)) begin
							emit      = 1'b1;
							emit_long = 1'b1;
							emit_map  = map_set;
							open_n    = 1'b0;
							map_n     = '0;
						end else begin
							map_n = map_set;
						end
					end else begin
						emit      = cluster_open_q;
						open_n    = 1'b1;
						encoder_n = s1.item.hit_encoder;
						base_n    = s1.item.hit_address;
						map_n     = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign emit_map_ext = {WMAP_W'(0), emit_map};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_open_q <= 1'b0;
			open_encoder_q <= '0;
			open_base_q    <= '0;
			open_map_q     <= '0;
			word_valid_q   <= 1'b0;
		end else if (advance) begin
			word_valid_q <= s1.valid && emit;
			if (s1.valid) begin
				cluster_open_q <= open_n;
				open_encoder_q <= encoder_n;
				open_base_q    <= base_n;
				open_map_q     <= map_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1.valid && emit) begin
			word_long_q    <= emit_long;
			word_encoder_q <= emit_encoder;
			word_base_q    <= emit_base;
			word_map_q     <= emit_long ? emit_map_ext[WMAP_W-1:0] : '0;
		end
	end

	assign word.valid        = word_valid_q;
	assign word.word_long    = word_long_q;
	assign word.word_encoder = word_encoder_q;
	assign word.word_base    = word_base_q;
	assign word.word_map     = word_map_q;

endmodule

@@ rtl/pixel_hit_cluster_encoder.sv @@
// Pixel hit cluster encoder: packs a priority-encoded hit stream of one region
// into short and long data words. One request item is accepted per clock cycle
// while the word register is not held by word.ready; an item passes an input
// register and the cluster logic into the word register. The rate is set by the
// combinational join and hitmap update against the registered open cluster.
// clustering resets to 1; the user must write it only while the block is idle,
// as the block itself does not enforce this. Depends on phce_pkg, phce_req_if,
// phce_word_if, phce_cfg_if, phce_in_reg and phce_cluster.
module pixel_hit_cluster_encoder #(
	parameter int unsigned MAP_BITS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	phce_cfg_if.sink    cfg,
	phce_req_if.sink    req,
	phce_word_if.source word
);
	import phce_pkg::*;

	logic   clustering_q;
	logic   advance;
	stage_t s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clustering_q <= 1'b1;
		end else if (cfg.valid) begin
			clustering_q <= cfg.clustering;
		end
	end

	phce_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.advance (advance),
		.s1      (s1)
	);

	phce_cluster #(
		.MAP_BITS (MAP_BITS)
	) u_cluster (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1         (s1),
		.clustering (clustering_q),
		.advance    (advance),
		.word       (word)
	);

endmodule
